@@ rtl/pmtsep_pkg.sv @@
// ----------------------------------------------------------------------------
// PMT entry parser package
// Shared widths, stream type codes, track kinds and the result struct.
// ----------------------------------------------------------------------------
package pmtsep_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LEN_W   = 10;
  localparam int unsigned PID_W   = 13;
  localparam int unsigned SKIP_W  = 12;
  localparam int unsigned KIND_W  = 2;

  // Stream type codes that map to a track kind.
  localparam logic [BYTE_W-1:0] ST_MPEG2_VIDEO = 8'h02;
  localparam logic [BYTE_W-1:0] ST_MPEG1_AUDIO = 8'h03;
  localparam logic [BYTE_W-1:0] ST_MPEG2_AUDIO = 8'h04;
  localparam logic [BYTE_W-1:0] ST_H264_VIDEO  = 8'h1b;
  localparam logic [BYTE_W-1:0] ST_AC3_AUDIO   = 8'h81;

  // Track kinds.
  localparam logic [KIND_W-1:0] KIND_MPEG2_VIDEO = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MPEG_AUDIO  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_H264_VIDEO  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_AC3_AUDIO   = 2'd3;

  typedef struct packed {
    logic              known;
    logic [KIND_W-1:0] kind;
  } kind_lookup_t;

  typedef struct packed {
    logic              hit;
    logic [KIND_W-1:0] kind;
    logic [PID_W-1:0]  pid;
    logic [BYTE_W-1:0] stype;
  } entry_result_t;

  function automatic kind_lookup_t kind_of(input logic [BYTE_W-1:0] stype);
    kind_lookup_t r;
    r.known = 1'b1;
    unique case (stype)
      ST_MPEG2_VIDEO: r.kind = KIND_MPEG2_VIDEO;
      ST_MPEG1_AUDIO: r.kind = KIND_MPEG_AUDIO;
      ST_MPEG2_AUDIO: r.kind = KIND_MPEG_AUDIO;
      ST_H264_VIDEO:  r.kind = KIND_H264_VIDEO;
      ST_AC3_AUDIO:   r.kind = KIND_AC3_AUDIO;
      default: begin
        r.known = 1'b0;
        r.kind  = KIND_MPEG2_VIDEO;
      end
    endcase
    return r;
  endfunction

endpackage

@@ rtl/pmtsep_core.sv @@
// ----------------------------------------------------------------------------
// PMT entry parser core
// Holds the parse state and consumes one payload byte per step, producing
// an entry result on the last byte of each recognized elementary stream entry.
// ----------------------------------------------------------------------------
module pmtsep_core
  import pmtsep_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              payload_start,
  input  logic [LEN_W-1:0]  payload_length,
  output entry_result_t     result
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_PROG_SKIP,
    PH_ENTRY,
    PH_ES_SKIP,
    PH_DONE
  } phase_t;

  phase_t             phase, phase_next;
  logic [2:0]         idx, idx_next;
  logic [LEN_W-1:0]   remaining, remaining_next;
  logic [SKIP_W-1:0]  skip, skip_next;
  logic [BYTE_W-1:0]  held_type, held_type_next;
  logic [PID_W-1:0]   held_pid, held_pid_next;

  phase_t             phase_v;
  logic [2:0]         idx_v;
  logic [LEN_W-1:0]   rem_v, rem_dec;
  logic [SKIP_W-1:0]  skip_v, skip_full, skip_dec;
  phase_t             loop_phase;
  kind_lookup_t       lookup;

  always_comb begin
    // A start byte restarts the parse before it is consumed.
    phase_v   = payload_start ? PH_HEADER : phase;
    idx_v     = payload_start ? 3'd0 : idx;
    rem_v     = payload_start ? payload_length : remaining;
    skip_v    = payload_start ? '0 : skip;
    rem_dec   = rem_v - LEN_W'(1);
    skip_full = skip_v | SKIP_W'(data_byte);
    skip_dec  = skip_v - SKIP_W'(1);
    loop_phase = (rem_dec > LEN_W'(4)) ? PH_ENTRY : PH_DONE;
    lookup    = kind_of(held_type);

    phase_next     = phase_v;
    idx_next       = idx_v;
    remaining_next = rem_v;
    skip_next      = skip_v;
    held_type_next = held_type;
    held_pid_next  = held_pid;
    result         = '{hit: 1'b0, kind: lookup.kind, pid: held_pid, stype: held_type};

    if (phase_v != PH_IDLE && phase_v != PH_DONE) begin
      if (rem_v == '0) begin
        phase_next = PH_DONE;
      end else begin
        remaining_next = rem_dec;
        unique case (phase_v)
          PH_HEADER: begin
            if (idx_v == 3'd2) begin
              skip_next = {data_byte[3:0], 8'h00};
              idx_next  = 3'd3;
            end else if (idx_v == 3'd3) begin
              skip_next = skip_full;
              if (skip_full != '0) begin
                phase_next = PH_PROG_SKIP;
              end else begin
                idx_next   = 3'd0;
                phase_next = loop_phase;
              end
            end else begin
              idx_next = idx_v + 3'd1;
            end
          end
          PH_PROG_SKIP, PH_ES_SKIP: begin
            skip_next = skip_dec;
            if (skip_dec == '0) begin
              idx_next   = 3'd0;
              phase_next = loop_phase;
            end
          end
          PH_ENTRY: begin
            if (idx_v == 3'd0) begin
              held_type_next = data_byte;
              idx_next       = 3'd1;
            end else if (idx_v == 3'd1) begin
              held_pid_next = {data_byte[4:0], 8'h00};
              idx_next      = 3'd2;
            end else if (idx_v == 3'd2) begin
              held_pid_next = held_pid | PID_W'(data_byte);
              idx_next      = 3'd3;
            end else if (idx_v == 3'd3) begin
              skip_next = {data_byte[3:0], 8'h00};
              idx_next  = 3'd4;
            end else begin
              skip_next  = skip_full;
              result.hit = lookup.known;
              if (skip_full != '0) begin
                phase_next = PH_ES_SKIP;
              end else begin
                idx_next   = 3'd0;
                phase_next = loop_phase;
              end
            end
          end
          default: phase_next = PH_DONE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      idx       <= '0;
      remaining <= '0;
      skip      <= '0;
      held_type <= '0;
      held_pid  <= '0;
    end else if (step) begin
      phase     <= phase_next;
      idx       <= idx_next;
      remaining <= remaining_next;
      skip      <= skip_next;
      held_type <= held_type_next;
      held_pid  <= held_pid_next;
    end
  end

endmodule

@@ rtl/pmt_stream_entry_parser_top.sv @@
// A transaction that completes a recognized entry passes through the input register
// and then the result register before its result shows; a stall can hold it between them.
// Throughput: one byte per cycle; the input register and the result register
// are the only two stages and both advance every cycle unless the output stalls.
// Reset: synchronous, active high; clears both stages and the parse state,
// after which the parser ignores bytes until a payload start arrives.
// ----------------------------------------------------------------------------
// PMT stream entry parser, top level
// Parses the elementary stream entries of a PMT section payload, one byte
// per transaction, and reports the track kind, PID and stream type of each
// entry whose stream type is recognized.
// ----------------------------------------------------------------------------
module pmt_stream_entry_parser_top
  import pmtsep_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              payload_start,
  input  logic [LEN_W-1:0]  payload_length,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [KIND_W-1:0] track_kind,
  output logic [PID_W-1:0]  elementary_pid,
  output logic [BYTE_W-1:0] stream_type_code
);

  // Input register. It holds one accepted byte until the parse step can
  // run, which is whenever the result register is free or being emptied.
  logic              s1_valid;
  logic [BYTE_W-1:0] s1_byte;
  logic              s1_start;
  logic [LEN_W-1:0]  s1_length;

  logic              advance;
  entry_result_t     step_result;

  // The parse step runs when a byte is held and its possible result has
  // somewhere to go. Bytes that produce no result still wait for this, so
  // result order always matches byte order.
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte   <= data_byte;
      s1_start  <= payload_start;
      s1_length <= payload_length;
    end
  end

  pmtsep_core u_core (
    .clk            (clk),
    .rst            (rst),
    .step           (advance),
    .data_byte      (s1_byte),
    .payload_start  (s1_start),
    .payload_length (s1_length),
    .result         (step_result)
  );

  // Result register. A new result loads when the step produces one;
  // otherwise a taken result simply drains.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= step_result.hit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step_result.hit) begin
      track_kind       <= step_result.kind;
      elementary_pid   <= step_result.pid;
      stream_type_code <= step_result.stype;
    end
  end

endmodule

@@ rtl/pmtsep_checker.sv @@
// ----------------------------------------------------------------------------
// PMT entry parser checker
// Port-level checks on the top level, attached by a bind statement.
// ----------------------------------------------------------------------------
module pmtsep_checker
  import pmtsep_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [KIND_W-1:0] track_kind,
  input logic [PID_W-1:0]  elementary_pid,
  input logic [BYTE_W-1:0] stream_type_code
);

  // A stalled result keeps its payload.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(track_kind)
      && $stable(elementary_pid) && $stable(stream_type_code))
    else $error("result changed while stalled");

  // Reset empties the result register.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // With the output draining, the input side never stalls.
  assert property (@(posedge clk) disable iff (rst) out_ready |-> in_ready)
    else $error("input stalled while output is ready");

  // The reported kind agrees with the reported stream type.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |->
      (stream_type_code == ST_MPEG2_VIDEO && track_kind == KIND_MPEG2_VIDEO) ||
      (stream_type_code == ST_MPEG1_AUDIO && track_kind == KIND_MPEG_AUDIO) ||
      (stream_type_code == ST_MPEG2_AUDIO && track_kind == KIND_MPEG_AUDIO) ||
      (stream_type_code == ST_H264_VIDEO && track_kind == KIND_H264_VIDEO) ||
      (stream_type_code == ST_AC3_AUDIO && track_kind == KIND_AC3_AUDIO))
    else $error("track kind does not match stream type");

endmodule

bind pmt_stream_entry_parser_top pmtsep_checker u_pmtsep_checker (
  .clk              (clk),
  .rst              (rst),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .track_kind       (track_kind),
  .elementary_pid   (elementary_pid),
  .stream_type_code (stream_type_code)
);

@@ tb/tb_pmt_stream_entry_parser_top.sv @@
// ----------------------------------------------------------------------------
// PMT stream entry parser testbench
// Feeds PMT section payloads to the parser one byte per transaction and
// tracks the same section walk in a behavioral parser of its own. Every
// elementary stream entry with a recognized stream type is expected as one
// result transaction, and results are checked in order, field by field.
// ----------------------------------------------------------------------------
module tb_pmt_stream_entry_parser_top;
  import pmtsep_pkg::*;

  // Stimulus runs until about this many bytes have been sent.
  localparam int unsigned ITEM_GOAL   = 1650;
  // Length of the long receiver hold-off used to fill the pipeline.
  localparam int unsigned HOLD_CYCLES = 300;
  // Bound on the final drain, and the extra cycles after it. The parser
  // shows an entry once the byte that completes it passes the input and result registers.
  localparam int unsigned DRAIN_LIMIT = 5000;
  localparam int unsigned TAIL_CYCLES = 8;
  localparam int unsigned MAX_PRINTS  = 40;

  // Private stream type: parsed as an entry but never reported.
  localparam logic [BYTE_W-1:0] ST_PRIVATE = 8'h06;

  // Where the parse stands within the current payload.
  typedef enum logic [2:0] {
    SEC_IDLE,
    SEC_HEADER,
    SEC_PROG_SKIP,
    SEC_ENTRY,
    SEC_ES_SKIP,
    SEC_DONE
  } sec_phase_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [PID_W-1:0]  pid;
    logic [BYTE_W-1:0] stype;
  } track_entry_t;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic [BYTE_W-1:0] data_byte;
  logic              payload_start;
  logic [LEN_W-1:0]  payload_length;
  logic              out_valid;
  logic              out_ready;
  logic [KIND_W-1:0] track_kind;
  logic [PID_W-1:0]  elementary_pid;
  logic [BYTE_W-1:0] stream_type_code;

  // Behavioral copy of the parse state.
  sec_phase_t        sec_phase;
  logic [2:0]        sec_idx;
  logic [10:0]       sec_left;
  logic [SKIP_W-1:0] sec_skip;
  logic [BYTE_W-1:0] sec_stype;
  logic [PID_W-1:0]  sec_pid;

  // Entries predicted but not yet seen at the output, oldest first.
  track_entry_t      pending_entries[$];
  // Payload under construction by the section builders.
  logic [BYTE_W-1:0] section_bytes[$];

  int unsigned error_count  = 0;
  int unsigned sent_count   = 0;
  int unsigned burst_left   = 0;
  // Each increment asks the receiver for one long hold-off.
  int unsigned hold_off_req = 0;

  pmt_stream_entry_parser_top dut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    if (error_count < MAX_PRINTS) $display("ERROR at %0t: %s", $time, what);
    error_count++;
  endtask

  // Maps a stream type to its track kind; returns 0 for types with no kind.
  function automatic bit known_track_kind(input logic [BYTE_W-1:0] stype,
                                          output logic [KIND_W-1:0] kind);
    kind = KIND_MPEG2_VIDEO;
    case (stype)
      ST_MPEG2_VIDEO: return 1'b1;
      ST_MPEG1_AUDIO, ST_MPEG2_AUDIO: begin
        kind = KIND_MPEG_AUDIO;
        return 1'b1;
      end
      ST_H264_VIDEO: begin
        kind = KIND_H264_VIDEO;
        return 1'b1;
      end
      ST_AC3_AUDIO: begin
        kind = KIND_AC3_AUDIO;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // A new entry starts only while more than the four CRC bytes remain.
  task automatic begin_entry_loop();
    sec_idx   = 3'd0;
    sec_phase = (sec_left > 11'd4) ? SEC_ENTRY : SEC_DONE;
  endtask

  // Advances the behavioral parse by one accepted byte and queues the entry
  // that the byte completes, if any.
  task automatic parse_section_byte(input logic [BYTE_W-1:0] data, input logic start,
                                    input logic [LEN_W-1:0] len);
    track_entry_t      e;
    logic [KIND_W-1:0] kind;
    // A payload start abandons whatever parse was in progress.
    if (start) begin
      sec_left  = {1'b0, len};
      sec_phase = SEC_HEADER;
      sec_idx   = 3'd0;
      sec_skip  = '0;
    end
    if (sec_phase == SEC_IDLE || sec_phase == SEC_DONE) return;
    // Bytes beyond the payload end are ignored until the next start.
    if (sec_left == 11'd0) begin
      sec_phase = SEC_DONE;
      return;
    end
    sec_left = sec_left - 11'd1;
    case (sec_phase)
      SEC_HEADER: begin
        // Two PCR PID bytes, then the 12-bit program info length.
        if (sec_idx == 3'd2) begin
          sec_skip = {data[3:0], 8'h00};
          sec_idx  = 3'd3;
        end else if (sec_idx == 3'd3) begin
          sec_skip = sec_skip | {4'h0, data};
          if (sec_skip != '0) sec_phase = SEC_PROG_SKIP;
          else begin_entry_loop();
        end else begin
          sec_idx = sec_idx + 3'd1;
        end
      end
      SEC_PROG_SKIP, SEC_ES_SKIP: begin
        sec_skip = sec_skip - 12'd1;
        if (sec_skip == '0) begin_entry_loop();
      end
      SEC_ENTRY: begin
        case (sec_idx)
          3'd0: begin
            sec_stype = data;
            sec_idx   = 3'd1;
          end
          3'd1: begin
            sec_pid = {data[4:0], 8'h00};
            sec_idx = 3'd2;
          end
          3'd2: begin
            sec_pid = sec_pid | {5'h00, data};
            sec_idx = 3'd3;
          end
          3'd3: begin
            sec_skip = {data[3:0], 8'h00};
            sec_idx  = 3'd4;
          end
          default: begin
            sec_skip = sec_skip | {4'h0, data};
            if (known_track_kind(sec_stype, kind)) begin
              e.kind  = kind;
              e.pid   = sec_pid;
              e.stype = sec_stype;
              pending_entries = {pending_entries, e};
            end
            if (sec_skip != '0) sec_phase = SEC_ES_SKIP;
            else begin_entry_loop();
          end
        endcase
      end
      default: sec_phase = SEC_DONE;
    endcase
  endtask

  // Offers one byte and waits for its transaction. The sender runs in bursts
  // of random length; between bursts valid usually drops for a random pause.
  task automatic send_byte(input logic [BYTE_W-1:0] data, input logic start,
                           input logic [LEN_W-1:0] len);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 16);
    end
    burst_left--;
    in_valid       <= 1'b1;
    data_byte      <= data;
    payload_start  <= start;
    payload_length <= len;
    do @(posedge clk); while (!in_ready);
    sent_count++;
    parse_section_byte(data, start, len);
  endtask

  // Bytes with payload start low; the length field is random since the
  // parser samples it only on a start.
  task automatic send_noise(input int unsigned count);
    repeat (count) send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0,
                             LEN_W'($urandom_range(0, 1023)));
  endtask

  // Sends the built payload, marking its first byte as the payload start
  // with the given length, which need not match the bytes sent.
  task automatic send_section(input int unsigned len);
    foreach (section_bytes[i]) begin
      if (i == 0) send_byte(section_bytes[i], 1'b1, LEN_W'(len));
      else send_byte(section_bytes[i], 1'b0, LEN_W'($urandom_range(0, 1023)));
    end
    section_bytes.delete();
  endtask

  task automatic append_byte(input logic [BYTE_W-1:0] b);
    section_bytes = {section_bytes, b};
  endtask

  task automatic add_filler(input int unsigned count);
    repeat (count) append_byte(BYTE_W'($urandom_range(0, 255)));
  endtask

  // PCR PID, program info length with random reserved bits, then
  // descriptor bytes.
  task automatic add_header(input logic [SKIP_W-1:0] info_len, input int unsigned fill);
    logic [3:0] pad;
    pad = 4'($urandom);
    add_filler(2);
    append_byte({pad, info_len[11:8]});
    append_byte(info_len[7:0]);
    add_filler(fill);
  endtask

  // One elementary stream entry, with random reserved bits above the PID
  // and the ES info length, then its descriptor bytes.
  task automatic add_entry(input logic [BYTE_W-1:0] stype, input logic [PID_W-1:0] pid,
                           input logic [SKIP_W-1:0] es_len, input int unsigned fill);
    logic [2:0] pad3;
    logic [3:0] pad4;
    pad3 = 3'($urandom);
    pad4 = 4'($urandom);
    append_byte(stype);
    append_byte({pad3, pid[12:8]});
    append_byte(pid[7:0]);
    append_byte({pad4, es_len[11:8]});
    append_byte(es_len[7:0]);
    add_filler(fill);
  endtask

  // About half recognized types, with private and fully random types mixed in.
  function automatic logic [BYTE_W-1:0] pick_stream_type();
    case ($urandom_range(0, 9))
      0: return ST_MPEG2_VIDEO;
      1: return ST_MPEG1_AUDIO;
      2: return ST_MPEG2_AUDIO;
      3: return ST_H264_VIDEO;
      4: return ST_AC3_AUDIO;
      5: return ST_PRIVATE;
      default: return BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Bytes before any payload start must be ignored.
  task automatic test_idle_bytes();
    send_noise(3);
  endtask

  // A start with zero length is ignored, and so is everything after it.
  task automatic test_zero_length();
    send_byte(BYTE_W'($urandom_range(0, 255)), 1'b1, '0);
    send_noise(2);
  endtask

  // Every recognized stream type, PID extremes, and types with no kind.
  task automatic test_track_kinds();
    add_header('0, 0);
    add_entry(ST_MPEG2_VIDEO, '0, '0, 0);
    add_entry(ST_MPEG1_AUDIO, '1, 12'd1, 1);
    add_entry(ST_MPEG2_AUDIO, PID_W'($urandom), 12'd2, 2);
    add_entry(ST_H264_VIDEO, PID_W'($urandom), '0, 0);
    add_entry(ST_AC3_AUDIO, PID_W'($urandom), '0, 0);
    add_entry(ST_PRIVATE, PID_W'($urandom), 12'd1, 1);
    add_entry(8'h00, PID_W'($urandom), '0, 0);
    add_entry(8'hff, PID_W'($urandom), '0, 0);
    add_filler(4);
    send_section(section_bytes.size());
  endtask

  // Program info descriptors are skipped, and a program info length that
  // runs past the payload end stops at the end.
  task automatic test_program_info();
    add_header(12'd3, 3);
    add_entry(ST_H264_VIDEO, PID_W'($urandom), '0, 0);
    add_filler(4);
    send_section(section_bytes.size());
    add_header('1, 2);
    send_section(section_bytes.size());
    send_noise(2);
  endtask

  // Loop end and payload end: CRC bytes are never parsed, an entry may end
  // exactly at the payload end, and a long ES info length stops at the end.
  task automatic test_payload_end();
    add_header('0, 0);
    add_filler(3);
    send_section(section_bytes.size());
    add_header('0, 0);
    add_entry(ST_AC3_AUDIO, PID_W'($urandom), '0, 0);
    send_section(section_bytes.size());
    send_noise(2);
    add_header('0, 0);
    add_entry(ST_MPEG2_VIDEO, PID_W'($urandom), '1, 3);
    send_section(section_bytes.size());
  endtask

  // A new payload start in the middle of an entry abandons it.
  task automatic test_restart();
    add_header('0, 0);
    add_entry(ST_MPEG1_AUDIO, PID_W'($urandom), '0, 0);
    append_byte(ST_AC3_AUDIO);
    add_filler(2);
    send_section(40);
    add_header('0, 0);
    add_entry(pick_stream_type(), PID_W'($urandom), '0, 0);
    add_entry(ST_MPEG2_AUDIO, PID_W'($urandom), '0, 0);
    add_filler(4);
    send_section(section_bytes.size());
  endtask

  // Lengths above the nominal maximum are used as given; the following
  // start cuts these payloads short.
  task automatic test_long_length();
    for (int unsigned len = 1022; len <= 1023; len++) begin
      add_header('0, 0);
      add_entry(ST_H264_VIDEO, PID_W'($urandom), '0, 0);
      add_entry(pick_stream_type(), PID_W'($urandom), 12'd1, 1);
      add_filler(4);
      send_section(len);
    end
  endtask

  // The receiver holds off for a long stretch while the sender keeps
  // offering entry bytes, so the pipeline fills and the input stalls.
  task automatic test_backpressure();
    hold_off_req++;
    burst_left = 400;
    add_header('0, 0);
    repeat (12) add_entry(ST_H264_VIDEO, PID_W'($urandom), '0, 0);
    add_filler(4);
    send_section(section_bytes.size());
  endtask

  // Mostly well-formed payloads with random content and small sizes; the
  // rest have wrong lengths, cut-off bytes, oversized descriptor lengths,
  // or stray bytes between payloads.
  task automatic test_random_sections();
    int unsigned entries;
    int unsigned info;
    int unsigned es;
    int unsigned len;
    while (sent_count < ITEM_GOAL) begin
      if ($urandom_range(0, 19) == 0) begin
        add_header(SKIP_W'($urandom_range(0, 4095)), $urandom_range(0, 3));
      end else begin
        info = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        add_header(SKIP_W'(info), info);
      end
      entries = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 6);
      repeat (entries) begin
        es = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
        if ($urandom_range(0, 15) == 0) begin
          add_entry(pick_stream_type(), PID_W'($urandom),
                    SKIP_W'($urandom_range(0, 4095)), es);
        end else begin
          add_entry(pick_stream_type(), PID_W'($urandom), SKIP_W'(es), es);
        end
      end
      add_filler(4);
      len = section_bytes.size();
      case ($urandom_range(0, 19))
        0, 1: len = len - $urandom_range(1, len);
        2: len = len + $urandom_range(1, 8);
        3: len = $urandom_range(0, 1023);
        4: repeat ($urandom_range(1, section_bytes.size() - 1)) void'(section_bytes.pop_back());
        default: ;
      endcase
      send_section(len);
      if ($urandom_range(0, 9) == 0) send_noise($urandom_range(1, 4));
    end
  endtask

  // Receiver: ready follows a pattern that is picked anew at regular intervals,
  // from always ready through mostly stalled to alternating. A hold-off request
  // from the stimulus overrides it for the length of HOLD_CYCLES.
  initial begin : rx_pattern
    int unsigned cycle;
    logic [1:0]  mode;
    int unsigned hold_off_seen;
    out_ready <= 1'b0;
    cycle         = 0;
    mode          = 2'd0;
    hold_off_seen = 0;
    forever begin
      @(posedge clk);
      cycle++;
      if (hold_off_req != hold_off_seen) begin
        hold_off_seen = hold_off_req;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (cycle % 97 == 0) mode = 2'($urandom_range(0, 3));
        case (mode)
          2'd0: out_ready <= 1'b1;
          2'd1: out_ready <= ($urandom_range(0, 3) != 0);
          2'd2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= cycle[0];
        endcase
      end
    end
  end

  // Every result transaction is matched against the oldest predicted entry.
  // Signals are read right after the edge, so they hold the values that the
  // edge itself sampled.
  initial begin : entry_checker
    track_entry_t want;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (pending_entries.size() == 0) begin
          report_mismatch($sformatf("unexpected entry kind %0d pid 0x%0h type 0x%0h",
                                    track_kind, elementary_pid, stream_type_code));
        end else begin
          want = pending_entries.pop_front();
          if (track_kind !== want.kind)
            report_mismatch($sformatf("track_kind %0d, expected %0d", track_kind, want.kind));
          if (elementary_pid !== want.pid)
            report_mismatch($sformatf("elementary_pid 0x%0h, expected 0x%0h",
                                      elementary_pid, want.pid));
          if (stream_type_code !== want.stype)
            report_mismatch($sformatf("stream_type_code 0x%0h, expected 0x%0h",
                                      stream_type_code, want.stype));
        end
      end
    end
  end

  // Main sequence: reset once, run each test in turn, then drain.
  initial begin : main_seq
    int unsigned waited;
    rst            <= 1'b1;
    in_valid       <= 1'b0;
    data_byte      <= '0;
    payload_start  <= 1'b0;
    payload_length <= '0;
    sec_phase = SEC_IDLE;
    sec_idx   = 3'd0;
    sec_left  = '0;
    sec_skip  = '0;
    sec_stype = '0;
    sec_pid   = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_idle_bytes();
    test_zero_length();
    test_track_kinds();
    test_program_info();
    test_payload_end();
    test_restart();
    test_long_length();
    test_backpressure();
    test_random_sections();

    // All bytes are in; wait for the last entries to come out, then give
    // the pipeline TAIL_CYCLES more to show anything spurious.
    in_valid <= 1'b0;
    waited = 0;
    while (pending_entries.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_entries.size() != 0)
      report_mismatch($sformatf("%0d expected entries never arrived", pending_entries.size()));

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Hard stop in case a handshake never completes.
  initial begin : watchdog
    #1000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
